[rtl/gamepad_serial_poll_master_macros.svh]
// Assertion macros for the gamepad serial poll master.
`ifndef GAMEPAD_SERIAL_POLL_MASTER_MACROS_SVH
`define GAMEPAD_SERIAL_POLL_MASTER_MACROS_SVH

// Same-cycle implication under reset.
`define GSPM_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under reset.
`define GSPM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/gspm_pkg.sv]
// Package: command codes, frame constants and frame content functions.
`default_nettype none

package gspm_pkg;

    typedef enum logic [3:0] {
        CMD_NONE   = 4'd0,
        CMD_READ   = 4'd1,
        CMD_MODE   = 4'd2,
        CMD_SHORT  = 4'd3,
        CMD_VIB    = 4'd4,
        CMD_ENTER  = 4'd5,
        CMD_ANALOG = 4'd6,
        CMD_VIBEN  = 4'd7,
        CMD_EXIT   = 4'd8,
        CMD_SETUP  = 4'd9
    } cmd_t;

    localparam logic REG_CLOCK_HALF = 1'b0;
    localparam logic REG_BYTE_GAP   = 1'b1;

    localparam logic [7:0] CLOCK_HALF_RESET = 8'd4;
    localparam logic [7:0] BYTE_GAP_RESET   = 8'd16;

    localparam logic [3:0] FRAME_BYTES = 4'd9;
    localparam logic [3:0] SHORT_BYTES = 4'd5;
    localparam logic [3:0] MODE_BYTES  = 4'd2;

    localparam logic [7:0] ADDR_BYTE   = 8'h01;
    localparam logic [7:0] POLL_BYTE   = 8'h42;
    localparam logic [7:0] CFG_BYTE    = 8'h43;
    localparam logic [7:0] ANALOG_BYTE = 8'h44;
    localparam logic [7:0] LOCK_BYTE   = 8'hEE;
    localparam logic [7:0] VIBMAP_BYTE = 8'h4D;
    localparam logic [7:0] EXIT_FILL   = 8'h5A;
    localparam logic [7:0] ON_BYTE     = 8'h01;
    localparam logic [7:0] ANALOG_ID   = 8'h73;
    localparam logic [7:0] STICK_FLIP  = 8'h80;
    localparam logic [7:0] STICK_TOP   = 8'd127;

    localparam int IN_BITS  = 24;
    localparam int OUT_BITS = 56;

    function automatic logic [3:0] frame_len(input logic [3:0] kind);
        logic [3:0] n;
        n = FRAME_BYTES;
        if (kind == CMD_MODE) n = MODE_BYTES;
        else if (kind == CMD_SHORT || kind == CMD_VIBEN) n = SHORT_BYTES;
        return n;
    endfunction

    function automatic logic has_lead(input logic [3:0] kind);
        return (kind >= CMD_SHORT) && (kind != CMD_ANALOG);
    endfunction

    function automatic logic has_tail(input logic [3:0] kind);
        return kind >= CMD_SHORT;
    endfunction

    function automatic cmd_t chain_frame(input logic [2:0] step);
        cmd_t k;
        unique case (step)
            3'd0, 3'd1, 3'd2: k = CMD_SHORT;
            3'd3:             k = CMD_ENTER;
            3'd4:             k = CMD_ANALOG;
            3'd5:             k = CMD_VIBEN;
            3'd6:             k = CMD_EXIT;
            default:          k = CMD_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [7:0] frame_byte(input logic [3:0] kind,
                                              input logic [3:0] b,
                                              input logic [15:0] motor);
        logic [7:0] v;
        v = 8'h00;
        if (b == 4'd0) begin
            v = ADDR_BYTE;
        end else begin
            unique case (kind)
                CMD_READ, CMD_MODE, CMD_SHORT: begin
                    if (b == 4'd1) v = POLL_BYTE;
                end
                CMD_VIB: begin
                    if (b == 4'd1) v = POLL_BYTE;
                    else if (b == 4'd3) v = motor[15:8];
                    else if (b == 4'd4) v = motor[7:0];
                end
                CMD_ENTER: begin
                    if (b == 4'd1) v = CFG_BYTE;
                    else if (b == 4'd3) v = ON_BYTE;
                end
                CMD_ANALOG: begin
                    if (b == 4'd1) v = ANALOG_BYTE;
                    else if (b == 4'd3) v = ON_BYTE;
                    else if (b == 4'd4) v = LOCK_BYTE;
                end
                CMD_VIBEN: begin
                    if (b == 4'd1) v = VIBMAP_BYTE;
                    else if (b == 4'd4) v = ON_BYTE;
                end
                CMD_EXIT: begin
                    if (b == 4'd1) v = CFG_BYTE;
                    else if (b >= 4'd4) v = EXIT_FILL;
                end
                default: v = 8'h00;
            endcase
        end
        return v;
    endfunction

endpackage

`default_nettype wire

[rtl/gamepad_serial_poll_master.sv]
// Gamepad serial poll master: tick-driven frame sequencer with registered result.
// The result for a request is registered when it is accepted and presented in the cycle after.
// Throughput: one request (tick) per cycle; s_axis_tready is high whenever the
// result register is empty or is being taken in the same cycle.
// Reset (aresetn low, synchronous): sequencer idle, replies and ID cleared,
// clock half period 4 and byte gap 16 ticks, result register empty.
`default_nettype none
`include "gamepad_serial_poll_master_macros.svh"

module gamepad_serial_poll_master (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_addr,
    input  wire logic [7:0]  cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [3:0] cmd, [11:4] motor_small, [19:12] motor_large, [20] data_in
    input  wire logic [gspm_pkg::IN_BITS-1:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [0] chip_select_n, [1] clock_out, [2] command_out, [3] busy_res,
    // [4] frame_done, [12:5] mode_id, [13] analog_mode, [18:14] pressed_key,
    // [26:19] stick_ch0, [34:27] stick_ch1, [42:35] stick_ch2, [50:43] stick_ch3
    output logic [gspm_pkg::OUT_BITS-1:0] m_axis_tdata
);

    typedef enum logic [2:0] {
        PH_IDLE, PH_LEAD, PH_HIGH, PH_LOW, PH_GAP, PH_TAIL
    } phase_t;

    logic [7:0]  clock_half_reg;
    logic [7:0]  byte_gap_reg;
    logic [7:0]  reply_reg [6];
    logic [7:0]  reply_next [6];
    logic [7:0]  id_reg, id_next;
    logic [7:0]  shift_reg, shift_next;
    logic [2:0]  bit_reg, bit_next;
    logic [3:0]  byte_reg, byte_next;
    logic [3:0]  kind_reg, kind_next;
    logic [2:0]  chain_reg, chain_next;
    phase_t      phase_reg, phase_next;
    logic [7:0]  tick_reg, tick_next;
    logic [15:0] motor_reg, motor_next;
    logic        m_valid_reg;
    logic [gspm_pkg::OUT_BITS-1:0] m_data_reg;

    logic        accept;
    logic        done;
    logic        start_en;
    logic [3:0]  start_kind;
    logic        finish;
    logic [7:0]  len;
    logic [7:0]  tick_inc;
    logic [3:0]  byte_inc;
    logic [2:0]  reply_idx;
    logic [15:0] hk;
    logic [4:0]  key;
    logic [7:0]  cur_byte;
    logic        cmd_bit;
    logic [gspm_pkg::OUT_BITS-1:0] result;

    logic [3:0]  in_cmd;
    logic [7:0]  in_small;
    logic [7:0]  in_large;
    logic        in_din;

    assign in_cmd   = s_axis_tdata[3:0];
    assign in_small = s_axis_tdata[11:4];
    assign in_large = s_axis_tdata[19:12];
    assign in_din   = s_axis_tdata[20];

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    assign reply_idx = 3'(byte_reg - 4'd3);
    assign tick_inc  = tick_reg + 8'd1;
    assign byte_inc  = byte_reg + 4'd1;

    always_comb begin
        if (phase_reg == PH_HIGH || phase_reg == PH_LOW) len = clock_half_reg;
        else len = byte_gap_reg;
        if (len == 8'd0) len = 8'd1;
    end

    always_comb begin
        reply_next = reply_reg;
        id_next    = id_reg;
        shift_next = shift_reg;
        bit_next   = bit_reg;
        byte_next  = byte_reg;
        kind_next  = kind_reg;
        chain_next = chain_reg;
        phase_next = phase_reg;
        tick_next  = tick_reg;
        motor_next = motor_reg;
        done       = 1'b0;
        start_en   = 1'b0;
        start_kind = gspm_pkg::CMD_NONE;
        finish     = 1'b0;

        if (accept) begin
            if (phase_reg == PH_IDLE) begin
                if (in_cmd >= gspm_pkg::CMD_READ && in_cmd <= gspm_pkg::CMD_EXIT) begin
                    if (in_cmd == gspm_pkg::CMD_VIB) motor_next = {in_small, in_large};
                    chain_next = 3'd0;
                    start_en   = 1'b1;
                    start_kind = in_cmd;
                end else if (in_cmd == gspm_pkg::CMD_SETUP) begin
                    chain_next = 3'd1;
                    start_en   = 1'b1;
                    start_kind = gspm_pkg::chain_frame(3'd0);
                end
            end else if (tick_inc >= len) begin
                tick_next = 8'd0;
                unique case (phase_reg)
                    PH_LEAD: phase_next = PH_HIGH;
                    PH_HIGH: phase_next = PH_LOW;
                    PH_LOW: begin
                        if (in_din) shift_next[bit_reg] = 1'b1;
                        if (bit_reg != 3'd7) begin
                            bit_next   = bit_reg + 3'd1;
                            phase_next = PH_HIGH;
                        end else begin
                            if (kind_reg != gspm_pkg::CMD_READ || byte_reg < 4'd2) begin
                                id_next = shift_next;
                            end else if (byte_reg >= 4'd3 && byte_reg <= 4'd8) begin
                                reply_next[reply_idx] = shift_next;
                            end
                            phase_next = PH_GAP;
                        end
                    end
                    PH_GAP: begin
                        byte_next = byte_inc;
                        if (byte_inc < gspm_pkg::frame_len(kind_reg)) begin
                            bit_next   = 3'd0;
                            shift_next = 8'd0;
                            phase_next = PH_HIGH;
                        end else if (gspm_pkg::has_tail(kind_reg)) begin
                            phase_next = PH_TAIL;
                        end else begin
                            finish = 1'b1;
                        end
                    end
                    default: finish = 1'b1;
                endcase
                if (finish) begin
                    if (chain_reg >= 3'd1 && chain_reg <= 3'd6) begin
                        start_en   = 1'b1;
                        start_kind = gspm_pkg::chain_frame(chain_reg);
                        chain_next = chain_reg + 3'd1;
                    end else begin
                        chain_next = 3'd0;
                        kind_next  = gspm_pkg::CMD_NONE;
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                end
            end else begin
                tick_next = tick_inc;
            end

            if (start_en) begin
                kind_next  = start_kind;
                byte_next  = 4'd0;
                bit_next   = 3'd0;
                shift_next = 8'd0;
                tick_next  = 8'd0;
                if (start_kind == gspm_pkg::CMD_READ) begin
                    for (int i = 0; i < 6; i++) reply_next[i] = 8'd0;
                end
                phase_next = gspm_pkg::has_lead(start_kind) ? PH_LEAD : PH_HIGH;
            end
        end
    end

    // Result fields are taken from the updated state.
    assign hk = {reply_next[1], reply_next[0]};

    always_comb begin
        key = 5'd0;
        for (int i = 15; i >= 0; i--) begin
            if (!hk[i]) key = 5'(i + 1);
        end
    end

    assign cur_byte = gspm_pkg::frame_byte(kind_next, byte_next, motor_next);
    assign cmd_bit  = cur_byte[bit_next];

    always_comb begin
        result        = '0;
        result[0]     = (phase_next == PH_IDLE) || (phase_next == PH_TAIL);
        result[1]     = (phase_next != PH_LOW);
        result[2]     = (phase_next == PH_HIGH || phase_next == PH_LOW ||
                         phase_next == PH_GAP) ? cmd_bit : 1'b0;
        result[3]     = (phase_next != PH_IDLE);
        result[4]     = done;
        result[12:5]  = id_next;
        result[13]    = (id_next == gspm_pkg::ANALOG_ID);
        result[18:14] = key;
        result[26:19] = reply_next[2] ^ gspm_pkg::STICK_FLIP;
        result[34:27] = gspm_pkg::STICK_TOP - reply_next[3];
        result[42:35] = reply_next[4] ^ gspm_pkg::STICK_FLIP;
        result[50:43] = gspm_pkg::STICK_TOP - reply_next[5];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_half_reg <= gspm_pkg::CLOCK_HALF_RESET;
            byte_gap_reg   <= gspm_pkg::BYTE_GAP_RESET;
            for (int i = 0; i < 6; i++) reply_reg[i] <= 8'd0;
            id_reg      <= 8'd0;
            shift_reg   <= 8'd0;
            bit_reg     <= 3'd0;
            byte_reg    <= 4'd0;
            kind_reg    <= gspm_pkg::CMD_NONE;
            chain_reg   <= 3'd0;
            phase_reg   <= PH_IDLE;
            tick_reg    <= 8'd0;
            motor_reg   <= 16'd0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    gspm_pkg::REG_CLOCK_HALF: clock_half_reg <= cfg_wdata;
                    gspm_pkg::REG_BYTE_GAP:   byte_gap_reg   <= cfg_wdata;
                    default: ;
                endcase
            end
            reply_reg <= reply_next;
            id_reg    <= id_next;
            shift_reg <= shift_next;
            bit_reg   <= bit_next;
            byte_reg  <= byte_next;
            kind_reg  <= kind_next;
            chain_reg <= chain_next;
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            motor_reg <= motor_next;
            if (accept) m_valid_reg <= 1'b1;
            else if (m_axis_tready) m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) m_data_reg <= result;
    end

    `GSPM_ASSERT_NOW(a_idle_no_chain, aclk, aresetn, phase_reg == PH_IDLE, chain_reg == 3'd0, "chain step left in idle")
    `GSPM_ASSERT_NOW(a_bit_tick_range, aclk, aresetn, phase_reg == PH_HIGH || phase_reg == PH_LOW, tick_reg < len, "tick count beyond clock half period")
    `GSPM_ASSERT_NOW(a_byte_range, aclk, aresetn, phase_reg == PH_HIGH || phase_reg == PH_LOW || phase_reg == PH_GAP, byte_reg < gspm_pkg::frame_len(kind_reg), "byte index beyond frame")
    `GSPM_ASSERT_NOW(a_done_idle, aclk, aresetn, m_valid_reg && m_data_reg[4], !m_data_reg[3] && m_data_reg[0], "done reported while busy")
    `GSPM_ASSERT_NEXT(a_accept_result, aclk, aresetn, accept, m_valid_reg, "accepted request produced no result")

endmodule

`default_nettype wire

[verif/tb_gamepad_serial_poll_master.sv]
// Self-checking testbench for the gamepad serial poll master: tick stream in, pin state out.
`timescale 1ns / 100ps

module tb_gamepad_serial_poll_master;
    import gspm_pkg::*;

    localparam int unsigned TOTAL_ITEMS = 1450;
    localparam int unsigned STUCK_LIMIT = 2000;
    localparam int unsigned END_CYCLES  = 8;

    typedef enum logic [2:0] {
        PH_IDLE, PH_LEAD, PH_HIGH, PH_LOW, PH_GAP, PH_TAIL
    } pad_phase_t;

    // Tracks the sequencer tick by tick and holds the pin states still owed.
    class pad_scoreboard;
        logic [7:0]  half_ticks;
        logic [7:0]  gap_ticks;
        logic [7:0]  replies [6];
        logic [7:0]  id_byte;
        logic [7:0]  shift_byte;
        logic [2:0]  bit_idx;
        logic [3:0]  byte_idx;
        logic [3:0]  kind;
        logic [2:0]  chain_pos;
        pad_phase_t  ph;
        logic [7:0]  tick_cnt;
        logic [15:0] motor;
        logic [55:0] pending_pins [$];
        int unsigned errors;

        function new();
            half_ticks = CLOCK_HALF_RESET;
            gap_ticks  = BYTE_GAP_RESET;
            foreach (replies[i]) replies[i] = 8'h00;
            id_byte    = 8'h00;
            shift_byte = 8'h00;
            bit_idx    = 3'd0;
            byte_idx   = 4'd0;
            kind       = CMD_NONE;
            chain_pos  = 3'd0;
            ph         = PH_IDLE;
            tick_cnt   = 8'd0;
            motor      = 16'h0000;
            errors     = 0;
        endfunction

        function int unsigned frame_bytes(input logic [3:0] k);
            if (k == CMD_MODE) return 2;
            if (k == CMD_SHORT || k == CMD_VIBEN) return 5;
            return 9;
        endfunction

        function logic [3:0] chain_kind(input logic [2:0] s);
            case (s)
                3'd0, 3'd1, 3'd2: return CMD_SHORT;
                3'd3: return CMD_ENTER;
                3'd4: return CMD_ANALOG;
                3'd5: return CMD_VIBEN;
                default: return CMD_EXIT;
            endcase
        endfunction

        function logic [7:0] sent_byte(input logic [3:0] k, input logic [3:0] b);
            logic [7:0] v;
            v = 8'h00;
            if (b == 4'd0) begin
                v = ADDR_BYTE;
            end else begin
                case (k)
                    CMD_READ, CMD_MODE, CMD_SHORT: if (b == 4'd1) v = POLL_BYTE;
                    CMD_VIB: begin
                        if (b == 4'd1) v = POLL_BYTE;
                        else if (b == 4'd3) v = motor[15:8];
                        else if (b == 4'd4) v = motor[7:0];
                    end
                    CMD_ENTER: begin
                        if (b == 4'd1) v = CFG_BYTE;
                        else if (b == 4'd3) v = ON_BYTE;
                    end
                    CMD_ANALOG: begin
                        if (b == 4'd1) v = ANALOG_BYTE;
                        else if (b == 4'd3) v = ON_BYTE;
                        else if (b == 4'd4) v = LOCK_BYTE;
                    end
                    CMD_VIBEN: begin
                        if (b == 4'd1) v = VIBMAP_BYTE;
                        else if (b == 4'd4) v = ON_BYTE;
                    end
                    CMD_EXIT: begin
                        if (b == 4'd1) v = CFG_BYTE;
                        else if (b >= 4'd4) v = EXIT_FILL;
                    end
                    default: v = 8'h00;
                endcase
            end
            return v;
        endfunction

        function void open_frame(input logic [3:0] k);
            kind       = k;
            byte_idx   = 4'd0;
            bit_idx    = 3'd0;
            shift_byte = 8'h00;
            tick_cnt   = 8'd0;
            if (k == CMD_READ) foreach (replies[i]) replies[i] = 8'h00;
            ph = (k >= CMD_SHORT && k != CMD_ANALOG) ? PH_LEAD : PH_HIGH;
        endfunction

        function void note_tick(input logic [23:0] d);
            logic [3:0]  c;
            int unsigned len;
            bit          finish;
            bit          done;
            logic [15:0] held;
            logic [4:0]  key;
            logic [7:0]  out_byte;
            logic [55:0] e;
            c = d[3:0];
            finish = 1'b0;
            done = 1'b0;
            if (ph == PH_IDLE) begin
                if (c >= CMD_READ && c <= CMD_EXIT) begin
                    if (c == CMD_VIB) motor = {d[11:4], d[19:12]};
                    chain_pos = 3'd0;
                    open_frame(c);
                end else if (c == CMD_SETUP) begin
                    chain_pos = 3'd1;
                    open_frame(chain_kind(3'd0));
                end
            end else begin
                len = (ph == PH_HIGH || ph == PH_LOW) ? half_ticks : gap_ticks;
                if (len == 0) len = 1;
                tick_cnt = tick_cnt + 8'd1;
                if (tick_cnt >= len) begin
                    tick_cnt = 8'd0;
                    case (ph)
                        PH_LEAD: ph = PH_HIGH;
                        PH_HIGH: ph = PH_LOW;
                        PH_LOW: begin
                            if (d[20]) shift_byte[bit_idx] = 1'b1;
                            if (bit_idx < 3'd7) begin
                                bit_idx = bit_idx + 3'd1;
                                ph = PH_HIGH;
                            end else begin
                                if (kind != CMD_READ || byte_idx < 4'd2)
                                    id_byte = shift_byte;
                                else if (byte_idx >= 4'd3 && byte_idx <= 4'd8)
                                    replies[byte_idx - 4'd3] = shift_byte;
                                ph = PH_GAP;
                            end
                        end
                        PH_GAP: begin
                            byte_idx = byte_idx + 4'd1;
                            if (byte_idx < frame_bytes(kind)) begin
                                bit_idx = 3'd0;
                                shift_byte = 8'h00;
                                ph = PH_HIGH;
                            end else if (kind >= CMD_SHORT) begin
                                ph = PH_TAIL;
                            end else begin
                                finish = 1'b1;
                            end
                        end
                        default: finish = 1'b1;
                    endcase
                    if (finish) begin
                        if (chain_pos >= 3'd1 && chain_pos <= 3'd6) begin
                            open_frame(chain_kind(chain_pos));
                            chain_pos = chain_pos + 3'd1;
                        end else begin
                            chain_pos = 3'd0;
                            kind = CMD_NONE;
                            ph = PH_IDLE;
                            done = 1'b1;
                        end
                    end
                end
            end

            held = {replies[1], replies[0]};
            key = 5'd0;
            for (int i = 15; i >= 0; i--) if (!held[i]) key = 5'(i + 1);
            out_byte = sent_byte(kind, byte_idx);

            e = '0;
            e[0]     = (ph == PH_IDLE || ph == PH_TAIL);
            e[1]     = (ph != PH_LOW);
            e[2]     = (ph == PH_HIGH || ph == PH_LOW || ph == PH_GAP) ? out_byte[bit_idx] : 1'b0;
            e[3]     = (ph != PH_IDLE);
            e[4]     = done;
            e[12:5]  = id_byte;
            e[13]    = (id_byte == ANALOG_ID);
            e[18:14] = key;
            e[26:19] = replies[2] - STICK_FLIP;
            e[34:27] = STICK_TOP - replies[3];
            e[42:35] = replies[4] - STICK_FLIP;
            e[50:43] = STICK_TOP - replies[5];
            pending_pins.push_back(e);
        endfunction

        function void check_pins(input logic [55:0] a);
            logic [55:0] e;
            logic [55:0] ev;
            logic [55:0] av;
            int          lo;
            int          w;
            string       name;
            if (pending_pins.size() == 0) begin
                errors++;
                $display("%0t: result with nothing outstanding: %h", $time, a);
                return;
            end
            e = pending_pins.pop_front();
            for (int f = 0; f < 12; f++) begin
                case (f)
                    0:  begin name = "chip_select_n"; lo = 0;  w = 1; end
                    1:  begin name = "clock_out";     lo = 1;  w = 1; end
                    2:  begin name = "command_out";   lo = 2;  w = 1; end
                    3:  begin name = "busy_res";      lo = 3;  w = 1; end
                    4:  begin name = "frame_done";    lo = 4;  w = 1; end
                    5:  begin name = "mode_id";       lo = 5;  w = 8; end
                    6:  begin name = "analog_mode";   lo = 13; w = 1; end
                    7:  begin name = "pressed_key";   lo = 14; w = 5; end
                    8:  begin name = "stick_ch0";     lo = 19; w = 8; end
                    9:  begin name = "stick_ch1";     lo = 27; w = 8; end
                    10: begin name = "stick_ch2";     lo = 35; w = 8; end
                    default: begin name = "stick_ch3"; lo = 43; w = 8; end
                endcase
                ev = (e >> lo) & ~({56{1'b1}} << w);
                av = (a >> lo) & ~({56{1'b1}} << w);
                if (ev !== av) begin
                    errors++;
                    $display("%0t: %s expected %0h got %0h", $time, name, ev, av);
                end
            end
        endfunction
    endclass

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic        cfg_addr      = 1'b0;
    logic [7:0]  cfg_wdata     = 8'h00;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [IN_BITS-1:0]  s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [OUT_BITS-1:0] m_axis_tdata;

    pad_scoreboard sb;
    logic [7:0]    reply_plan [9];
    bit            plan_noise   = 1'b0;
    bit            steady       = 1'b0;
    int unsigned   stretch_left = 0;
    int unsigned   hold_left    = 0;
    int unsigned   stuck_cycles = 0;
    int unsigned   items_sent   = 0;

    gamepad_serial_poll_master uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 85) return 0;
        if (r < 98) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] pick_reply();
        case ($urandom_range(0, 7))
            0: return ANALOG_ID;
            1: return 8'hFF;
            2: return 8'h00;
            3: return ~(8'h01 << $urandom_range(0, 7));
            4: return STICK_FLIP;
            default: return 8'($urandom);
        endcase
    endfunction

    // Data pin follows the planned reply bytes, with the odd random level when noise is on.
    function automatic logic din_now();
        if (plan_noise && $urandom_range(0, 15) == 0) return 1'($urandom);
        if (sb.ph == PH_HIGH || sb.ph == PH_LOW) return reply_plan[sb.byte_idx][sb.bit_idx];
        return 1'($urandom);
    endfunction

    function automatic logic [3:0] ignored_cmd();
        if ($urandom_range(0, 6) == 0) return CMD_NONE;
        return 4'(int'(CMD_SETUP) + $urandom_range(1, 6));
    endfunction

    function automatic logic [3:0] busy_cmd();
        if ($urandom_range(0, 7) == 0) return 4'($urandom_range(1, 15));
        return CMD_NONE;
    endfunction

    always @(posedge aclk) begin
        if (stretch_left == 0) begin
            steady <= ($urandom_range(0, 3) == 0);
            stretch_left <= $urandom_range(100, 500);
        end else begin
            stretch_left <= stretch_left - 1;
        end
    end

    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_axis_tready <= 1'b1;
            hold_left <= pick_gap();
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) sb.check_pins(m_axis_tdata);
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            cfg_wr_en || !aresetn) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles == STUCK_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_tick(input logic [23:0] d);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tdata  <= d;
        s_axis_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        sb.note_tick(d);
        items_sent++;
    endtask

    task automatic idle_ticks(input int unsigned n);
        repeat (n) send_tick({3'b000, 1'($urandom), 16'($urandom), ignored_cmd()});
    endtask

    // One request from idle, then ticks until the sequencer is idle again.
    task automatic run_op(input logic [3:0] c, input logic [7:0] ms, input logic [7:0] ml,
                          input int fill);
        foreach (reply_plan[i]) reply_plan[i] = (fill < 0) ? pick_reply() : fill[7:0];
        plan_noise = (fill < 0);
        send_tick({3'b000, din_now(), ml, ms, c});
        while (sb.ph != PH_IDLE)
            send_tick({3'b000, din_now(), 8'($urandom), 8'($urandom), busy_cmd()});
    endtask

    task automatic random_op();
        int unsigned r;
        logic [3:0]  c;
        r = $urandom_range(0, 39);
        if (r < 2) c = ignored_cmd();
        else if (r < 14) c = CMD_READ;
        else c = 4'($urandom_range(int'(CMD_MODE), int'(CMD_EXIT)));
        run_op(c, 8'($urandom), 8'($urandom), -1);
        if ($urandom_range(0, 3) == 0) idle_ticks($urandom_range(1, 4));
    endtask

    task automatic set_timing(input logic [7:0] half, input logic [7:0] gap);
        s_axis_tvalid <= 1'b0;
        while (sb.pending_pins.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
        cfg_addr  <= REG_CLOCK_HALF;
        cfg_wdata <= half;
        cfg_wr_en <= 1'b1;
        @(posedge aclk);
        cfg_addr  <= REG_BYTE_GAP;
        cfg_wdata <= gap;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.half_ticks = half;
        sb.gap_ticks  = gap;
    endtask

    initial begin
        int unsigned gap;
        sb = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed pass at reset timing.
        run_op(CMD_NONE, 8'h00, 8'h00, 0);
        run_op(4'(int'(CMD_SETUP) + 1), 8'h00, 8'h00, 0);
        run_op(4'(int'(CMD_SETUP) + 6), 8'hFF, 8'hFF, 0);
        run_op(CMD_MODE, 8'h00, 8'h00, ANALOG_ID);

        // Zero acts as one; the setup chain walks every config frame.
        set_timing(8'd0, 8'd0);
        run_op(CMD_SETUP, 8'h00, 8'h00, -1);

        set_timing(8'd1, 8'd2);
        run_op(CMD_READ, 8'h00, 8'h00, -1);
        run_op(CMD_VIB, 8'($urandom), 8'($urandom), -1);

        while (items_sent < TOTAL_ITEMS) begin
            gap = $urandom_range(1, 2);
            set_timing(8'd1, 8'(gap));
            random_op();
        end

        s_axis_tvalid <= 1'b0;
        while (sb.pending_pins.size() != 0) @(posedge aclk);
        repeat (END_CYCLES) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
